### hw/rtl/b64se_pkg.sv
`default_nettype none

package b64se_pkg;

    // '=' padding character
    localparam logic [6:0] PAD_CHAR = 7'h3D;

    // one encoding group handed from the front to the back
    typedef struct packed {
        logic [7:0] byte_a;
        logic [7:0] byte_b;
        logic [7:0] byte_c;
        logic [1:0] nbytes;  // real bytes in the group: 1, 2 or 3
        logic       last;    // group closes the message
    } t_group;

    // queue status seen by the front and the back
    typedef struct packed {
        logic full;
        logic empty;
    } t_qflags;

    // sextet to character of the standard alphabet
    function automatic logic [6:0] sextet_char(input logic [5:0] v);
        logic [6:0] ch;
        begin
            ch = 7'h00;
            if (v < 6'd26) begin
                ch = 7'h41 + {1'b0, v};
            end else if (v < 6'd52) begin
                ch = 7'h61 + {1'b0, v} - 7'd26;
            end else if (v < 6'd62) begin
                ch = 7'h30 + {1'b0, v} - 7'd52;
            end else if (v == 6'd62) begin
                ch = 7'h2B;
            end else begin
                ch = 7'h2F;
            end
            return ch;
        end
    endfunction

endpackage

`default_nettype wire

### hw/rtl/b64se_front.sv
`default_nettype none

module b64se_front (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_accept,
    input  wire  [7:0]             i_in_byte,
    input  wire                    i_in_last,
    output logic                   o_grp_push,
    output b64se_pkg::t_group      o_grp
);
    import b64se_pkg::*;

    logic [15:0] r_held_bytes, n_held_bytes;
    logic [1:0]  r_held_count, n_held_count;
    logic [1:0]  w_cnt;
    logic        w_hold;

    // a pending count of three is treated as two
    assign w_cnt  = (r_held_count == 2'd3) ? 2'd2 : r_held_count;
    assign w_hold = (w_cnt < 2'd2) && !i_in_last;

    // group assembly and pending byte update
    always_comb begin
        n_held_bytes = r_held_bytes;
        n_held_count = r_held_count;
        o_grp_push   = 1'b0;
        o_grp.byte_a = i_in_byte;
        o_grp.byte_b = 8'h00;
        o_grp.byte_c = 8'h00;
        o_grp.nbytes = w_cnt + 2'd1;
        o_grp.last   = i_in_last;
        case (w_cnt)
            2'd1: begin
                o_grp.byte_a = r_held_bytes[15:8];
                o_grp.byte_b = i_in_byte;
            end
            2'd2: begin
                o_grp.byte_a = r_held_bytes[15:8];
                o_grp.byte_b = r_held_bytes[7:0];
                o_grp.byte_c = i_in_byte;
            end
            default: begin
            end
        endcase
        if (i_accept) begin
            if (w_hold) begin
                if (w_cnt == 2'd0) begin
                    n_held_bytes = {i_in_byte, 8'h00};
                end else begin
                    n_held_bytes = {r_held_bytes[15:8], i_in_byte};
                end
                n_held_count = w_cnt + 2'd1;
            end else begin
                o_grp_push   = 1'b1;
                n_held_bytes = 16'h0000;
                n_held_count = 2'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_bytes <= 16'h0000;
            r_held_count <= 2'd0;
        end else begin
            r_held_bytes <= n_held_bytes;
            r_held_count <= n_held_count;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/b64se_queue.sv
`default_nettype none

module b64se_queue #(
    parameter int DEPTH = 2
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_push,
    input  wire b64se_pkg::t_group i_grp,
    input  wire                    i_pop,
    output b64se_pkg::t_group      o_grp,
    output b64se_pkg::t_qflags     o_flags
);
    import b64se_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    t_group          r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            w_wr, w_rd;

    assign o_flags.full  = (r_count == CNT_FULL);
    assign o_flags.empty = (r_count == '0);
    assign w_wr  = i_push && !o_flags.full;
    assign w_rd  = i_pop && !o_flags.empty;
    assign o_grp = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_grp;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

### hw/rtl/b64se_back.sv
`default_nettype none

module b64se_back (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire b64se_pkg::t_group  i_grp,
    input  wire b64se_pkg::t_qflags i_qflags,
    output logic                    o_q_pop,
    input  wire                     i_pop,
    output logic                    o_empty,
    output logic [6:0]              o_out_char,
    output logic                    o_out_last
);
    import b64se_pkg::*;

    t_group      r_grp;
    logic        r_active;
    logic [1:0]  r_idx;
    logic        w_take, w_done;
    logic [5:0]  w_sextet;
    logic        w_pad;

    assign o_empty = !r_active;
    assign w_take  = r_active && i_pop;
    assign w_done  = w_take && (r_idx == 2'd3);
    assign o_q_pop = !i_qflags.empty && (!r_active || w_done);

    // character selection for the current position
    always_comb begin
        w_pad    = 1'b0;
        w_sextet = r_grp.byte_a[7:2];
        case (r_idx)
            2'd0: w_sextet = r_grp.byte_a[7:2];
            2'd1: w_sextet = {r_grp.byte_a[1:0], r_grp.byte_b[7:4]};
            2'd2: begin
                w_sextet = {r_grp.byte_b[3:0], r_grp.byte_c[7:6]};
                w_pad    = (r_grp.nbytes < 2'd2);
            end
            2'd3: begin
                w_sextet = r_grp.byte_c[5:0];
                w_pad    = (r_grp.nbytes < 2'd3);
            end
            default: begin
            end
        endcase
    end

    assign o_out_char = w_pad ? PAD_CHAR : sextet_char(w_sextet);
    assign o_out_last = r_grp.last && (r_idx == 2'd3);

    // group register
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_grp <= i_grp;
        end
    end

    // position within the group
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_idx    <= 2'd0;
        end else begin
            if (o_q_pop) begin
                r_active <= 1'b1;
                r_idx    <= 2'd0;
            end else if (w_done) begin
                r_active <= 1'b0;
                r_idx    <= 2'd0;
            end else if (w_take) begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

### hw/rtl/base64_stream_encoder.sv
// base64 stream encoder, standard alphabet with '=' padding
//
// input side: a byte and its last flag are written like a queue push; a
// transaction completes on a rising edge with push high and full low.
// output side: characters are read like a queue pop; while empty is low the
// oldest character and its last flag are on o_out_char / o_out_last, and a
// transaction completes on a rising edge with pop high and empty low.
// every third byte, or the byte flagged last, closes a group of four
// characters; a short final group is zero-filled and padded with '=', and
// out_last marks its fourth character.
// the byte that closes a group is written into the group queue, and the back
// end then loads that group into its group register before its first character
// is visible. the back end sends one character per cycle while pop is high and
// empty is low; the single character output port sets this rate.
// the group queue (QUEUE_DEPTH entries) lets bytes keep coming while the
// receiver stalls; full rises only when the queue is full.
// reset clears the pending bytes, the queue and the output; empty is high.
`default_nettype none

module base64_stream_encoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         push,
    output logic        full,
    input  wire  [7:0]  i_in_byte,
    input  wire         i_in_last,
    output logic        empty,
    input  wire         pop,
    output logic [6:0]  o_out_char,
    output logic        o_out_last
);
    import b64se_pkg::*;

    logic     w_accept;
    logic     w_grp_push;
    t_group   w_front_grp;
    t_group   w_queue_grp;
    t_qflags  w_qflags;
    logic     w_q_pop;

    assign full     = w_qflags.full;
    assign w_accept = push && !full;

    // byte collection
    b64se_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_in_byte  (i_in_byte),
        .i_in_last  (i_in_last),
        .o_grp_push (w_grp_push),
        .o_grp      (w_front_grp)
    );

    // group queue between front and back
    b64se_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_grp_push),
        .i_grp   (w_front_grp),
        .i_pop   (w_q_pop),
        .o_grp   (w_queue_grp),
        .o_flags (w_qflags)
    );

    // character output
    b64se_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_grp      (w_queue_grp),
        .i_qflags   (w_qflags),
        .o_q_pop    (w_q_pop),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_out_char (o_out_char),
        .o_out_last (o_out_last)
    );

    // a group is never pushed into a full queue
    a_no_push_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_grp_push |-> !w_qflags.full)
        else $error("group pushed into full queue");

    // a last byte always leaves work pending in the next cycle
    a_last_pending : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in_last) |=> (!w_qflags.empty || !empty))
        else $error("last byte produced no group");

    // output is empty right after reset
    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("output not empty after reset");

    // the queue never pops while empty; it drains into an idle or finishing back end
    a_pop_nonempty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> !w_qflags.empty)
        else $error("pop from empty queue");

endmodule

`default_nettype wire
